### src/aarm_pkg.sv
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    typedef logic signed [15:0] t_s16;

    typedef struct packed {
        t_s16 axis_x;
        t_s16 axis_y;
        t_s16 axis_z;
        t_s16 angle;
    } t_in;

    typedef struct packed {
        t_s16 m11;
        t_s16 m12;
        t_s16 m13;
        t_s16 m21;
        t_s16 m22;
        t_s16 m23;
        t_s16 m31;
        t_s16 m32;
        t_s16 m33;
    } t_out;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] v;
        begin
            unique case (i)
                0: v = 34'sd843314856;
                1: v = 34'sd497837829;
                2: v = 34'sd263043836;
                3: v = 34'sd133525158;
                4: v = 34'sd67021686;
                5: v = 34'sd33543515;
                6: v = 34'sd16775850;
                7: v = 34'sd8388437;
                8: v = 34'sd4194282;
                9: v = 34'sd2097149;
                10: v = 34'sd1048575;
                11: v = 34'sd524287;
                12: v = 34'sd262143;
                13: v = 34'sd131071;
                14: v = 34'sd65535;
                15: v = 34'sd32767;
                16: v = 34'sd16383;
                17: v = 34'sd8191;
                18: v = 34'sd4095;
                19: v = 34'sd2047;
                20: v = 34'sd1023;
                21: v = 34'sd511;
                22: v = 34'sd255;
                23: v = 34'sd127;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

### src/aarm_if.sv
`timescale 1ns / 1ps
interface aarm_in_if;
    import aarm_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aarm_out_if;
    import aarm_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/aarm_sincos.sv
`timescale 1ns / 1ps
module aarm_sincos
    import aarm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_s16               i_angle,
    input  t_s16               i_ax,
    input  t_s16               i_ay,
    input  t_s16               i_az,
    output logic               o_valid,
    output logic signed [17:0] o_cos,
    output logic signed [17:0] o_sin,
    output t_s16               o_ax,
    output t_s16               o_ay,
    output t_s16               o_az
);

    // stage 0: angle in q.30 mod 2pi; 2^18 * angle spans under +-1.3 two-pi turns
    logic signed [35:0] w_a30;
    logic signed [35:0] w_r;
    assign w_a30 = 36'(i_angle) <<< 18;

    // parallel compares pick the multiple of two pi, then a single add
    always_comb begin
        if (w_a30 < -TWO_PI_Q30) begin
            w_r = w_a30 + (TWO_PI_Q30 <<< 1);
        end else if (w_a30 < 0) begin
            w_r = w_a30 + TWO_PI_Q30;
        end else if (w_a30 >= TWO_PI_Q30) begin
            w_r = w_a30 - TWO_PI_Q30;
        end else begin
            w_r = w_a30;
        end
    end

    logic signed [35:0] r_r;
    logic               r_v0;
    t_s16               r_ax0, r_ay0, r_az0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
        if (i_en) begin
            r_r   <= w_r;
            r_ax0 <= i_ax;
            r_ay0 <= i_ay;
            r_az0 <= i_az;
        end
    end

    // stage 1: fold into [-pi/2, pi/2]
    logic signed [35:0] w_f;
    logic               w_neg;
    always_comb begin
        logic signed [35:0] v;
        v = r_r;
        w_neg = 1'b0;
        if (v >= PI_Q30) v = v - TWO_PI_Q30;
        if (v > HALF_PI_Q30) begin
            v = v - PI_Q30;
            w_neg = 1'b1;
        end else if (v < -HALF_PI_Q30) begin
            v = v + PI_Q30;
            w_neg = 1'b1;
        end
        w_f = v;
    end

    logic signed [33:0] r_x [0:NSTEP];
    logic signed [33:0] r_y [0:NSTEP];
    logic signed [33:0] r_z [0:NSTEP];
    logic               r_vc [0:NSTEP];
    logic               r_ng [0:NSTEP];
    t_s16               r_cx [0:NSTEP];
    t_s16               r_cy [0:NSTEP];
    t_s16               r_cz [0:NSTEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc[0] <= 1'b0;
        end else if (i_en) begin
            r_vc[0] <= r_v0;
        end
        if (i_en) begin
            r_x[0]  <= GAIN_Q30;
            r_y[0]  <= '0;
            r_z[0]  <= 34'(w_f);
            r_ng[0] <= w_neg;
            r_cx[0] <= r_ax0;
            r_cy[0] <= r_ay0;
            r_cz[0] <= r_az0;
        end
    end

    // one cordic iteration per stage
    for (genvar g = 0; g < NSTEP; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vc[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vc[g+1] <= r_vc[g];
            end
            if (i_en) begin
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(g);
                end
                r_ng[g+1] <= r_ng[g];
                r_cx[g+1] <= r_cx[g];
                r_cy[g+1] <= r_cy[g];
                r_cz[g+1] <= r_cz[g];
            end
        end
    end

    logic signed [34:0] w_xs, w_ys;
    logic signed [34:0] w_xr, w_yr;
    assign w_xs = r_ng[NSTEP] ? -35'(r_x[NSTEP]) : 35'(r_x[NSTEP]);
    assign w_ys = r_ng[NSTEP] ? -35'(r_y[NSTEP]) : 35'(r_y[NSTEP]);
    assign w_xr = (w_xs + 35'sd8192) >>> 14;
    assign w_yr = (w_ys + 35'sd8192) >>> 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vc[NSTEP];
        end
        if (i_en) begin
            o_cos <= w_xr[17:0];
            o_sin <= w_yr[17:0];
            o_ax  <= r_cx[NSTEP];
            o_ay  <= r_cy[NSTEP];
            o_az  <= r_cz[NSTEP];
        end
    end

endmodule

### src/aarm_matrix.sv
`timescale 1ns / 1ps
module aarm_matrix
    import aarm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [17:0] i_cos,
    input  logic signed [17:0] i_sin,
    input  t_s16               i_ax,
    input  t_s16               i_ay,
    input  t_s16               i_az,
    output logic               o_valid,
    output t_out               o_data
);

    // stage a: axis products (q.28), t, axis*sin
    logic               r_va;
    logic signed [31:0] r_p [0:5];   // xx xy xz yy yz zz
    logic signed [18:0] r_t;
    logic signed [17:0] r_c;
    logic signed [33:0] r_xs, r_ys, r_zs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
        if (i_en) begin
            r_p[0] <= i_ax * i_ax;
            r_p[1] <= i_ax * i_ay;
            r_p[2] <= i_ax * i_az;
            r_p[3] <= i_ay * i_ay;
            r_p[4] <= i_ay * i_az;
            r_p[5] <= i_az * i_az;
            r_t    <= 19'sd65536 - 19'(i_cos);
            r_c    <= i_cos;
            r_xs   <= 34'(i_ax) * 34'(i_sin);
            r_ys   <= 34'(i_ay) * 34'(i_sin);
            r_zs   <= 34'(i_az) * 34'(i_sin);
        end
    end

    // stage b: products times t (q.44)
    logic               r_vb;
    logic signed [50:0] r_q [0:5];
    logic signed [33:0] r_xs2, r_ys2, r_zs2;
    logic signed [17:0] r_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_vb <= r_va;
        end
        if (i_en) begin
            for (int j = 0; j < 6; j++) begin
                r_q[j] <= 51'(r_p[j]) * 51'(r_t);
            end
            r_xs2 <= r_xs;
            r_ys2 <= r_ys;
            r_zs2 <= r_zs;
            r_c2  <= r_c;
        end
    end

    // stage c: sums
    logic               r_vc;
    logic signed [52:0] r_s [0:8];
    logic signed [52:0] w_cd, w_xs, w_ys, w_zs;
    assign w_cd = 53'(r_c2) <<< 28;
    assign w_xs = 53'(r_xs2) <<< 14;
    assign w_ys = 53'(r_ys2) <<< 14;
    assign w_zs = 53'(r_zs2) <<< 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_vc <= r_vb;
        end
        if (i_en) begin
            r_s[0] <= 53'(r_q[0]) + w_cd;
            r_s[1] <= 53'(r_q[1]) - w_zs;
            r_s[2] <= 53'(r_q[2]) + w_ys;
            r_s[3] <= 53'(r_q[1]) + w_zs;
            r_s[4] <= 53'(r_q[3]) + w_cd;
            r_s[5] <= 53'(r_q[4]) - w_xs;
            r_s[6] <= 53'(r_q[2]) - w_ys;
            r_s[7] <= 53'(r_q[4]) + w_xs;
            r_s[8] <= 53'(r_q[5]) + w_cd;
        end
    end

    function automatic t_s16 round_sat(input logic signed [52:0] v);
        logic signed [52:0] r;
        begin
            r = (v + 53'sd536870912) >>> 30;
            if (r > 53'sd32767) return 16'sh7fff;
            if (r < -53'sd32768) return 16'sh8000;
            return r[15:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vc;
        end
        if (i_en) begin
            o_data.m11 <= round_sat(r_s[0]);
            o_data.m12 <= round_sat(r_s[1]);
            o_data.m13 <= round_sat(r_s[2]);
            o_data.m21 <= round_sat(r_s[3]);
            o_data.m22 <= round_sat(r_s[4]);
            o_data.m23 <= round_sat(r_s[5]);
            o_data.m31 <= round_sat(r_s[6]);
            o_data.m32 <= round_sat(r_s[7]);
            o_data.m33 <= round_sat(r_s[8]);
        end
    end

endmodule

### src/axis_angle_rotation_matrix_core.sv
`timescale 1ns / 1ps
// axis-angle to 3x3 rotation matrix (rodrigues), fully pipelined
// input channel: axis_x, axis_y, axis_z (q1.14) and angle (q4.12, radians)
// output channel: m11..m33 (q2.14, saturating), one result beat per input beat
// the angle is reduced mod 2pi, folded, and run through one cordic stage per
// iteration; a multiplier tree then builds the nine entries
// pipeline from input beat to output valid: 2 reduction stages,
// CORDIC_STEPS cordic stages, 1 rounding stage and 4 matrix stages
// throughput: one beat per cycle while the receiver does not stall; every
// stage is a register with its own valid bit
// when the receiver stalls, the whole pipe holds; in_ready stays high while
// the output register is empty, so no beat is lost or repeated
// reset clears all valid bits; the pipe holds no other state
module axis_angle_rotation_matrix_core
    import aarm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    aarm_in_if.sink   s_in,
    aarm_out_if.source m_out
);

    logic w_en;
    logic w_sv;
    logic signed [17:0] w_cos, w_sin;
    t_s16 w_ax, w_ay, w_az;

    // pipe advances whenever the output slot is free or being drained
    assign w_en = !m_out.valid || m_out.ready;
    assign s_in.ready = w_en;

    aarm_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_in.valid),
        .i_angle (s_in.data.angle),
        .i_ax    (s_in.data.axis_x),
        .i_ay    (s_in.data.axis_y),
        .i_az    (s_in.data.axis_z),
        .o_valid (w_sv),
        .o_cos   (w_cos),
        .o_sin   (w_sin),
        .o_ax    (w_ax),
        .o_ay    (w_ay),
        .o_az    (w_az)
    );

    aarm_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_az    (w_az),
        .o_valid (m_out.valid),
        .o_data  (m_out.data)
    );

endmodule

### src/aarm_checker.sv
`timescale 1ns / 1ps
module aarm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped under stall");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken during stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind axis_angle_rotation_matrix_core aarm_checker u_aarm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (s_in.valid),
    .i_in_ready  (s_in.ready),
    .i_out_valid (m_out.valid),
    .i_out_ready (m_out.ready)
);
